FILE: rtl/peak_based_gain_stepper_assert.svh
// Assertion macros shared by the gain stepper RTL.
// Needs nothing else; included by the modules that carry assertions.
`ifndef PEAK_BASED_GAIN_STEPPER_ASSERT_SVH
`define PEAK_BASED_GAIN_STEPPER_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define PBGS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define PBGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pbgs_pkg.sv
// Package for the peak based gain stepper: widths, operation codes, queue item type,
// factor unit request and response types and the Q.16 gain factor constants.
// No dependencies.
package pbgs_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int TBL_AW      = $clog2(TABLE_DEPTH);
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

   localparam int OP_W    = 2;
   localparam int LEVEL_W = 8;
   localparam int IDX_W   = 5;
   localparam int GAIN_W  = 9;
   localparam int COUNT_W = 6;

   localparam logic [COUNT_W-1:0] GAIN_COUNT_RESET = 6'd29;
   localparam logic [LEVEL_W-1:0] LEVEL_FULL       = 8'd255;
   localparam logic [LEVEL_W-1:0] LEVEL_ZERO       = 8'd0;

   // Q.16 factor arithmetic
   localparam int Q16_STEPS = GAIN_W;
   localparam int STEP_W    = $clog2(Q16_STEPS);
   localparam int FRAC_W    = 16;
   localparam int RATIO_W   = 25;
   localparam int CONST_W   = 21;
   localparam int PROD_W    = RATIO_W + CONST_W;
   localparam int CHECK_W   = RATIO_W + LEVEL_W;
   localparam int Q16_ONE   = 65536;
   localparam int Q16_HALF  = 32768;
   localparam int CHECK_LIMIT = 256 * 65536;

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE = 2'd0,
      OP_TICK   = 2'd1,
      OP_LOAD   = 2'd2,
      OP_IDLE   = 2'd3
   } op_type;

   typedef struct packed {
      op_type               kind;
      logic [LEVEL_W-1:0]   sample;
      logic                 start_of_block;
      logic [IDX_W-1:0]     table_index;
      logic [GAIN_W-1:0]    table_value;
   } item_type;

   typedef struct packed {
      logic                 start;
      logic                 ack;
      logic [GAIN_W-1:0]    delta;
      logic [LEVEL_W-1:0]   level;
   } fac_req_type;

   typedef struct packed {
      logic                 done;
      logic                 step_ok;
   } fac_rsp_type;

   // 10^(2^k/200) in Q.16
   function automatic logic [CONST_W-1:0] factor_q16(input logic [STEP_W-1:0] k);
      logic [CONST_W-1:0] f;
      unique case (k)
         4'd0:    f = 21'd66295;
         4'd1:    f = 21'd67063;
         4'd2:    f = 21'd68625;
         4'd3:    f = 21'd71859;
         4'd4:    f = 21'd78792;
         4'd5:    f = 21'd94728;
         4'd6:    f = 21'd136924;
         4'd7:    f = 21'd286075;
         4'd8:    f = 21'd1248763;
         default: f = 21'd65536;
      endcase
      return f;
   endfunction

endpackage

FILE: rtl/pbgs_if.sv
// Handshake interfaces of the gain stepper: request, response and register write channels.
// Depends on pbgs_pkg for field widths.
interface pbgs_req_if import pbgs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      operation;
   logic [LEVEL_W-1:0]   sample;
   logic                 start_of_block;
   logic [IDX_W-1:0]     table_index;
   logic [GAIN_W-1:0]    table_value;

   modport source (output valid, operation, sample, start_of_block, table_index,
                   table_value, input ready);
   modport sink   (input valid, operation, sample, start_of_block, table_index,
                   table_value, output ready);
endinterface

interface pbgs_rsp_if import pbgs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 gain_changed;
   logic [GAIN_W-1:0]    applied_gain_out;
   logic [IDX_W-1:0]     gain_position;
   logic [LEVEL_W-1:0]   min_level;
   logic [LEVEL_W-1:0]   max_level;

   modport source (output valid, gain_changed, applied_gain_out, gain_position,
                   min_level, max_level, input ready);
   modport sink   (input valid, gain_changed, applied_gain_out, gain_position,
                   min_level, max_level, output ready);
endinterface

interface pbgs_csr_if import pbgs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [COUNT_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/pbgs_front.sv
// Front end: accepts request transactions, decodes the operation and queues items
// for the back end. Depends on pbgs_pkg, pbgs_if and the assertion macros.
`include "peak_based_gain_stepper_assert.svh"

module pbgs_front import pbgs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   pbgs_req_if.sink     req,
   output item_type     head_item,
   output logic         head_valid,
   input  logic         head_pop
);

   item_type               fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]     count_ff, count_in;
   logic                   push;
   item_type               new_item;

   assign req.ready  = (count_ff != FIFO_CW'(FIFO_DEPTH));
   assign push       = req.valid && req.ready;
   assign head_valid = (count_ff != '0);
   assign head_item  = fifo_ff[rd_ptr_ff];

   always_comb begin
      new_item.kind           = op_type'(req.operation);
      new_item.sample         = req.sample;
      new_item.start_of_block = req.start_of_block;
      new_item.table_index    = req.table_index;
      new_item.table_value    = req.table_value;
   end

   // pointers wrap naturally: the depth is a power of two
   always_comb begin
      wr_ptr_in = push     ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = head_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !head_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && head_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `PBGS_ASSERT_NOW(a_pop_not_empty, clock, reset, head_pop, count_ff != '0, "pop from empty queue")
   `PBGS_ASSERT_NEXT(a_push_grows, clock, reset, push && !head_pop, count_ff == $past(count_ff) + 3'd1, "queue count did not grow")
   `PBGS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= FIFO_CW'(FIFO_DEPTH), "queue count beyond depth")

endmodule

FILE: rtl/pbgs_factor.sv
// Gain factor unit: builds 10^(delta/200) in Q.16 one delta bit per cycle on a shared
// multiplier, then checks level * factor against full scale. Depends on pbgs_pkg.
module pbgs_factor import pbgs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  fac_req_type  fac_req,
   output fac_rsp_type  fac_rsp
);

   typedef enum logic [1:0] {
      F_IDLE  = 2'd0,
      F_RUN   = 2'd1,
      F_CHECK = 2'd2,
      F_DONE  = 2'd3
   } fstate_type;

   fstate_type             state_ff, state_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [RATIO_W-1:0]     ratio_ff, ratio_in;
   logic [GAIN_W-1:0]      delta_ff, delta_in;
   logic [LEVEL_W-1:0]     level_ff, level_in;
   logic                   ok_ff, ok_in;
   logic [PROD_W-1:0]      prod;
   logic [PROD_W-1:0]      rounded;
   logic [CHECK_W-1:0]     check;

   assign prod    = PROD_W'(ratio_ff) * PROD_W'(factor_q16(step_ff));
   assign rounded = prod + PROD_W'(Q16_HALF);
   assign check   = CHECK_W'(level_ff) * CHECK_W'(ratio_ff);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ratio_in = ratio_ff;
      delta_in = delta_ff;
      level_in = level_ff;
      ok_in    = ok_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (fac_req.start) begin
               delta_in = fac_req.delta;
               level_in = fac_req.level;
               ratio_in = RATIO_W'(Q16_ONE);
               step_in  = '0;
               state_in = F_RUN;
            end
         end
         F_RUN: begin
            // apply the factor for this bit when it is set, round half up
            if (delta_ff[step_ff]) begin
               ratio_in = rounded[FRAC_W +: RATIO_W];
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(Q16_STEPS - 1)) begin
               state_in = F_CHECK;
            end
         end
         F_CHECK: begin
            ok_in    = (check < CHECK_W'(CHECK_LIMIT));
            state_in = F_DONE;
         end
         F_DONE: begin
            if (fac_req.ack) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      ratio_ff <= ratio_in;
      delta_ff <= delta_in;
      level_ff <= level_in;
      ok_ff    <= ok_in;
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign fac_rsp.done    = (state_ff == F_DONE);
   assign fac_rsp.step_ok = ok_ff;

endmodule

FILE: rtl/pbgs_back.sv
// Back end: executes queued items against the running levels, the gain table and the
// gain position, and holds the response register. Depends on pbgs_pkg, pbgs_if,
// pbgs_factor (through its ports) and the assertion macros.
`include "peak_based_gain_stepper_assert.svh"

module pbgs_back import pbgs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [COUNT_W-1:0]   gain_count,
   input  item_type             head_item,
   input  logic                 head_valid,
   output logic                 head_pop,
   output fac_req_type          fac_req,
   input  fac_rsp_type          fac_rsp,
   pbgs_rsp_if.source           rsp
);

   typedef enum logic [1:0] {
      B_IDLE   = 2'd0,
      B_READ   = 2'd1,
      B_FACTOR = 2'd2
   } bstate_type;

   bstate_type             state_ff, state_in;
   logic [LEVEL_W-1:0]     run_min_ff, run_min_in;
   logic [LEVEL_W-1:0]     run_max_ff, run_max_in;
   logic [IDX_W-1:0]       gain_idx_ff, gain_idx_in;
   logic [GAIN_W-1:0]      applied_gain_ff, applied_gain_in;
   logic                   up_ff, up_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_changed_ff;
   logic [GAIN_W-1:0]      rsp_gain_ff;
   logic [IDX_W-1:0]       rsp_idx_ff;
   logic [LEVEL_W-1:0]     rsp_min_ff;
   logic [LEVEL_W-1:0]     rsp_max_ff;

   logic [GAIN_W-1:0]      table_mem [TABLE_DEPTH];
   logic [GAIN_W-1:0]      rd_data_ff;
   logic [TBL_AW-1:0]      rd_addr;
   logic                   rd_en;
   logic                   wr_en;

   logic                   changed_in;
   logic                   emit;
   logic                   out_free;
   logic                   clip;
   logic                   can_up;
   logic                   can_down;
   logic [COUNT_W-1:0]     cnt;
   logic [COUNT_W-1:0]     idx_ext;
   logic [LEVEL_W-1:0]     base_min;
   logic [LEVEL_W-1:0]     base_max;
   logic [GAIN_W-1:0]      delta;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign cnt      = (gain_count > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : gain_count;
   assign idx_ext  = COUNT_W'(gain_idx_ff);
   assign clip     = (run_min_ff == LEVEL_ZERO) || (run_max_ff == LEVEL_FULL);
   assign can_down = clip && (gain_idx_ff != '0) && (idx_ext <= cnt);
   assign can_up   = !clip && ((idx_ext + 1'b1) < cnt);
   assign delta    = (rd_data_ff > applied_gain_ff) ? rd_data_ff - applied_gain_ff : '0;
   assign base_min = head_item.start_of_block ? LEVEL_FULL : run_min_ff;
   assign base_max = head_item.start_of_block ? LEVEL_ZERO : run_max_ff;

   always_comb begin
      state_in        = state_ff;
      run_min_in      = run_min_ff;
      run_max_in      = run_max_ff;
      gain_idx_in     = gain_idx_ff;
      applied_gain_in = applied_gain_ff;
      up_in           = up_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      changed_in      = 1'b0;
      emit            = 1'b0;
      head_pop        = 1'b0;
      rd_en           = 1'b0;
      wr_en           = 1'b0;
      rd_addr         = TBL_AW'(gain_idx_ff);
      fac_req.start   = 1'b0;
      fac_req.ack     = 1'b0;
      fac_req.delta   = delta;
      fac_req.level   = run_max_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (head_valid) begin
               unique case (head_item.kind)
                  OP_TICK: begin
                     if (can_down || can_up) begin
                        // fetch the neighbouring entry; B_READ then steps down or starts the factor unit
                        head_pop = 1'b1;
                        rd_en    = 1'b1;
                        up_in    = can_up;
                        rd_addr  = can_up ? TBL_AW'(gain_idx_ff + 1'b1)
                                          : TBL_AW'(gain_idx_ff - 1'b1);
                        state_in = B_READ;
                     end else if (out_free) begin
                        head_pop = 1'b1;
                        emit     = 1'b1;
                     end
                  end
                  OP_SAMPLE: begin
                     if (out_free) begin
                        head_pop   = 1'b1;
                        emit       = 1'b1;
                        run_min_in = (head_item.sample < base_min) ? head_item.sample : base_min;
                        run_max_in = (head_item.sample > base_max) ? head_item.sample : base_max;
                     end
                  end
                  OP_LOAD: begin
                     if (out_free) begin
                        head_pop = 1'b1;
                        emit     = 1'b1;
                        wr_en    = ((IDX_W + 1)'(head_item.table_index) <
                                    (IDX_W + 1)'(TABLE_DEPTH));
                     end
                  end
                  OP_IDLE: begin
                     if (out_free) begin
                        head_pop = 1'b1;
                        emit     = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         B_READ: begin
            if (up_ff) begin
               fac_req.start = 1'b1;
               state_in      = B_FACTOR;
            end else if (out_free) begin
               gain_idx_in     = gain_idx_ff - 1'b1;
               applied_gain_in = rd_data_ff;
               changed_in      = (rd_data_ff != applied_gain_ff);
               emit            = 1'b1;
               state_in        = B_IDLE;
            end
         end
         B_FACTOR: begin
            if (fac_rsp.done && out_free) begin
               fac_req.ack = 1'b1;
               emit        = 1'b1;
               state_in    = B_IDLE;
               if (fac_rsp.step_ok) begin
                  gain_idx_in     = gain_idx_ff + 1'b1;
                  applied_gain_in = rd_data_ff;
                  changed_in      = (rd_data_ff != applied_gain_ff);
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[TBL_AW'(head_item.table_index)] <= head_item.table_value;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_changed_ff <= changed_in;
         rsp_gain_ff    <= applied_gain_in;
         rsp_idx_ff     <= gain_idx_in;
         rsp_min_ff     <= run_min_in;
         rsp_max_ff     <= run_max_in;
      end
      up_ff <= up_in;
      if (reset) begin
         state_ff        <= B_IDLE;
         run_min_ff      <= LEVEL_FULL;
         run_max_ff      <= LEVEL_ZERO;
         gain_idx_ff     <= '0;
         applied_gain_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         run_min_ff      <= run_min_in;
         run_max_ff      <= run_max_in;
         gain_idx_ff     <= gain_idx_in;
         applied_gain_ff <= applied_gain_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.gain_changed     = rsp_changed_ff;
   assign rsp.applied_gain_out = rsp_gain_ff;
   assign rsp.gain_position    = rsp_idx_ff;
   assign rsp.min_level        = rsp_min_ff;
   assign rsp.max_level        = rsp_max_ff;

   `PBGS_ASSERT_NOW(a_pop_idle, clock, reset, head_pop, state_ff == B_IDLE, "item taken while busy")
   `PBGS_ASSERT_NOW(a_start_read, clock, reset, fac_req.start, state_ff == B_READ && up_ff, "factor start outside step up")
   `PBGS_ASSERT_NEXT(a_changed_gain, clock, reset, emit && changed_in, applied_gain_ff != $past(applied_gain_ff), "change flagged without new gain")
   `PBGS_ASSERT_NEXT(a_idx_step, clock, reset, 1'b1, gain_idx_ff == $past(gain_idx_ff) || gain_idx_ff == $past(gain_idx_ff) + 5'd1 || gain_idx_ff == $past(gain_idx_ff) - 5'd1, "gain position jumped")

endmodule

FILE: rtl/peak_based_gain_stepper.sv
// Peak based gain stepper. Every request transaction (sample, control tick, table load or
// the spare code) produces exactly one response transaction, in order. Requests go into a
// four-entry queue and are executed by the back end: samples, loads, the spare code and
// ticks that cannot move run at one per clock while responses are taken. A tick that steps
// down holds the back end for the gain table read; one that may step up holds it while the
// factor unit applies one bit of the gain delta per cycle on a single multiplier and then
// checks the peak against full scale. The queue keeps taking requests meanwhile until it
// fills. The gain count register is written through the csr channel, which is always ready;
// the user must write it only while no request is in flight, as the block does not enforce
// it. Depends on pbgs_pkg, pbgs_if, pbgs_front, pbgs_factor and pbgs_back.
module peak_based_gain_stepper import pbgs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   pbgs_req_if.sink     req,
   pbgs_rsp_if.source   rsp,
   pbgs_csr_if.sink     csr
);

   logic [COUNT_W-1:0]  gain_count_ff, gain_count_in;
   item_type            head_item;
   logic                head_valid;
   logic                head_pop;
   fac_req_type         fac_req;
   fac_rsp_type         fac_rsp;

   assign csr.ready     = 1'b1;
   assign gain_count_in = (csr.valid && csr.ready) ? csr.data : gain_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_count_ff <= GAIN_COUNT_RESET;
      end else begin
         gain_count_ff <= gain_count_in;
      end
   end

   pbgs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .head_item  (head_item),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   pbgs_factor u_factor (
      .clock   (clock),
      .reset   (reset),
      .fac_req (fac_req),
      .fac_rsp (fac_rsp)
   );

   pbgs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .gain_count (gain_count_ff),
      .head_item  (head_item),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .fac_req    (fac_req),
      .fac_rsp    (fac_rsp),
      .rsp        (rsp)
   );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the peak based gain stepper: a table of directed requests,
// then random sample blocks, ticks and table loads over several gain count settings.
// Depends on pbgs_pkg, pbgs_if and the peak_based_gain_stepper RTL.
module tb_top;
   import pbgs_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int HOLD_CYCLES   = 80;
   localparam int PHASE_ITEMS   = 100;
   localparam int PHASES        = 8;
   localparam int GAIN_STEP     = 15;

   typedef struct packed {
      logic               changed;
      logic [GAIN_W-1:0]  gain;
      logic [IDX_W-1:0]   position;
      logic [LEVEL_W-1:0] min_level;
      logic [LEVEL_W-1:0] max_level;
   } level_report_type;

   typedef struct packed {
      item_type         req_item;
      logic             fixed;
      level_report_type report;
   } stim_row_type;

   // 10^(2^k/200) in Q.16, one per bit of the gain delta
   localparam longint unsigned STEP_FACTOR [GAIN_W] = '{
      64'd66295, 64'd67063, 64'd68625, 64'd71859, 64'd78792,
      64'd94728, 64'd136924, 64'd286075, 64'd1248763
   };

   localparam int PHASE_COUNT [PHASES] = '{32, 0, 12, 1, 63, 2, -1, 29};

   localparam int DIRECTED_ROWS = 24;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{'{OP_IDLE,   8'd255, 1'b1, 5'd31, 9'd511}, 1'b1, '{1'b0, 9'd0, 5'd0, 8'd255, 8'd0}},
      '{'{OP_SAMPLE, 8'd100, 1'b1, 5'd0,  9'd0},   1'b1, '{1'b0, 9'd0, 5'd0, 8'd100, 8'd100}},
      '{'{OP_SAMPLE, 8'd120, 1'b0, 5'd0,  9'd0},   1'b1, '{1'b0, 9'd0, 5'd0, 8'd100, 8'd120}},
      '{'{OP_TICK,   8'd0,   1'b0, 5'd0,  9'd0},   1'b0, '0},
      '{'{OP_SAMPLE, 8'd255, 1'b0, 5'd0,  9'd0},   1'b0, '0},
      '{'{OP_TICK,   8'd0,   1'b0, 5'd0,  9'd0},   1'b0, '0},
      '{'{OP_TICK,   8'd0,   1'b0, 5'd0,  9'd0},   1'b0, '0},
      '{'{OP_SAMPLE, 8'd0,   1'b1, 5'd0,  9'd0},   1'b0, '0},
      '{'{OP_TICK,   8'd0,   1'b0, 5'd0,  9'd0},   1'b0, '0},
      '{'{OP_SAMPLE, 8'd1,   1'b1, 5'd0,  9'd0},   1'b0, '0},
      '{'{OP_LOAD,   8'd0,   1'b0, 5'd1,  9'd511}, 1'b0, '0},
      '{'{OP_TICK,   8'd0,   1'b0, 5'd0,  9'd0},   1'b0, '0},
      '{'{OP_LOAD,   8'd0,   1'b0, 5'd1,  9'd15},  1'b0, '0},
      '{'{OP_TICK,   8'd0,   1'b0, 5'd0,  9'd0},   1'b0, '0},
      '{'{OP_TICK,   8'd0,   1'b0, 5'd0,  9'd0},   1'b0, '0},
      '{'{OP_LOAD,   8'd0,   1'b0, 5'd3,  9'd0},   1'b0, '0},
      '{'{OP_TICK,   8'd0,   1'b0, 5'd0,  9'd0},   1'b0, '0},
      '{'{OP_TICK,   8'd0,   1'b0, 5'd0,  9'd0},   1'b0, '0},
      '{'{OP_LOAD,   8'd0,   1'b0, 5'd3,  9'd45},  1'b0, '0},
      '{'{OP_SAMPLE, 8'd254, 1'b1, 5'd0,  9'd0},   1'b0, '0},
      '{'{OP_TICK,   8'd0,   1'b0, 5'd0,  9'd0},   1'b0, '0},
      '{'{OP_LOAD,   8'd0,   1'b0, 5'd31, 9'd511}, 1'b0, '0},
      '{'{OP_SAMPLE, 8'd2,   1'b0, 5'd0,  9'd0},   1'b0, '0},
      '{'{OP_TICK,   8'd0,   1'b0, 5'd0,  9'd0},   1'b0, '0}
   };

   logic clock;
   logic reset;

   pbgs_req_if req_bus ();
   pbgs_rsp_if rsp_bus ();
   pbgs_csr_if csr_bus ();

   peak_based_gain_stepper DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // Gain control state as the predictor sees it
   logic [LEVEL_W-1:0] agc_min;
   logic [LEVEL_W-1:0] agc_max;
   int                 agc_pos;
   logic [GAIN_W-1:0]  agc_gain;
   logic [GAIN_W-1:0]  agc_table [TABLE_DEPTH];
   int                 agc_count;

   level_report_type expected_reports [$];
   int               mismatches;
   bit               hold_rsp;
   bit               tail_quiet;
   bit               sender_calm;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLOCK_PERIOD * 400000);
      $display("Verification failed");
      $finish;
   end

   function automatic level_report_type advance_agc(input item_type it);
      level_report_type  rep;
      int                span;
      logic [GAIN_W-1:0] next_gain;
      logic [GAIN_W-1:0] cand;
      logic [GAIN_W-1:0] delta;
      longint unsigned   ratio;
      span      = (agc_count > TABLE_DEPTH) ? TABLE_DEPTH : agc_count;
      next_gain = agc_gain;
      rep       = '0;
      case (it.kind)
         OP_SAMPLE: begin
            if (it.start_of_block) begin
               agc_min = LEVEL_FULL;
               agc_max = LEVEL_ZERO;
            end
            if (it.sample < agc_min) agc_min = it.sample;
            if (it.sample > agc_max) agc_max = it.sample;
         end
         OP_TICK: begin
            if (agc_min == LEVEL_ZERO || agc_max == LEVEL_FULL) begin
               // clipping: step down, unless the entry below lies outside the count
               if (agc_pos > 0 && agc_pos - 1 < span) begin
                  agc_pos   = agc_pos - 1;
                  next_gain = agc_table[agc_pos];
               end
            end else if (agc_pos < span - 1) begin
               cand  = agc_table[agc_pos + 1];
               delta = (cand > agc_gain) ? cand - agc_gain : '0;
               ratio = 64'd65536;
               for (int k = 0; k < GAIN_W; k++) begin
                  if (delta[k]) ratio = (ratio * STEP_FACTOR[k] + 64'd32768) >> 16;
               end
               if (64'(agc_max) * ratio < 64'(CHECK_LIMIT)) begin
                  agc_pos   = agc_pos + 1;
                  next_gain = cand;
               end
            end
         end
         OP_LOAD: agc_table[it.table_index] = it.table_value;
         default: ;
      endcase
      if (next_gain != agc_gain) begin
         agc_gain    = next_gain;
         rep.changed = 1'b1;
      end
      rep.gain      = agc_gain;
      rep.position  = IDX_W'(agc_pos);
      rep.min_level = agc_min;
      rep.max_level = agc_max;
      return rep;
   endfunction

   // Hold valid until the transaction is taken, then record what must come back
   task automatic send_item(input item_type it, input logic fixed,
                            input level_report_type typed);
      level_report_type rep;
      req_bus.valid          <= 1'b1;
      req_bus.operation      <= it.kind;
      req_bus.sample         <= it.sample;
      req_bus.start_of_block <= it.start_of_block;
      req_bus.table_index    <= it.table_index;
      req_bus.table_value    <= it.table_value;
      do @(posedge clock); while (!req_bus.ready);
      rep = advance_agc(it);
      expected_reports.push_back(fixed ? typed : rep);
   endtask

   task automatic idle_sender();
      int n;
      if (!tail_quiet && !hold_rsp && !sender_calm && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 11);
         req_bus.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic write_gain_count(input logic [COUNT_W-1:0] count);
      req_bus.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= count;
      do @(posedge clock); while (!csr_bus.ready);
      agc_count      = count;
      csr_bus.valid <= 1'b0;
   endtask

   // Response sink: random stalls, one long hold-off, always ready at the tail
   initial begin
      int n;
      forever begin
         if (tail_quiet) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end else if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 11);
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            n = $urandom_range(1, 20);
            rsp_bus.ready <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      level_report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_reports.size() == 0) begin
            $error("response transaction with nothing expected");
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_bus.gain_changed !== want.changed) begin
               $error("gain_changed: expected %0d, got %0d", want.changed, rsp_bus.gain_changed);
               mismatches++;
            end
            if (rsp_bus.applied_gain_out !== want.gain) begin
               $error("applied_gain_out: expected %0d, got %0d",
                      want.gain, rsp_bus.applied_gain_out);
               mismatches++;
            end
            if (rsp_bus.gain_position !== want.position) begin
               $error("gain_position: expected %0d, got %0d", want.position,
                      rsp_bus.gain_position);
               mismatches++;
            end
            if (rsp_bus.min_level !== want.min_level) begin
               $error("min_level: expected %0d, got %0d", want.min_level, rsp_bus.min_level);
               mismatches++;
            end
            if (rsp_bus.max_level !== want.max_level) begin
               $error("max_level: expected %0d, got %0d", want.max_level, rsp_bus.max_level);
               mismatches++;
            end
         end
      end
   end

   initial begin
      item_type it;
      int       sent;
      int       pick;
      int       n;
      int       lim;
      int       count;
      mismatches  = 0;
      hold_rsp    = 1'b0;
      tail_quiet  = 1'b0;
      sender_calm = 1'b0;
      agc_min     = LEVEL_FULL;
      agc_max     = LEVEL_ZERO;
      agc_pos     = 0;
      agc_gain    = '0;
      agc_count   = GAIN_COUNT_RESET;
      foreach (agc_table[i]) agc_table[i] = '0;

      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.operation      <= OP_IDLE;
      req_bus.sample         <= '0;
      req_bus.start_of_block <= 1'b0;
      req_bus.table_index    <= '0;
      req_bus.table_value    <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.data           <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole gain table first so no tick ever reads an unloaded entry
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         it = '{OP_LOAD, LEVEL_ZERO, 1'b0, IDX_W'(i), GAIN_W'(i * GAIN_STEP)};
         idle_sender();
         send_item(it, 1'b0, '0);
      end

      foreach (DIRECTED[r]) begin
         idle_sender();
         send_item(DIRECTED[r].req_item, DIRECTED[r].fixed, DIRECTED[r].report);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         count = (PHASE_COUNT[ph] < 0) ? $urandom_range(3, 31) : PHASE_COUNT[ph];
         write_gain_count(COUNT_W'(count));
         tail_quiet  = (ph == PHASES - 1);
         sender_calm = (ph == 1 || ph == 5);
         if (ph == 2) hold_rsp = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               // one block of samples followed by one to three ticks
               n   = $urandom_range(2, 12);
               lim = ($urandom_range(0, 3) == 0) ? 254 : $urandom_range(1, 180);
               for (int k = 0; k < n; k++) begin
                  it.kind           = OP_SAMPLE;
                  it.sample         = LEVEL_W'($urandom_range(1, lim));
                  it.start_of_block = (k == 0);
                  it.table_index    = IDX_W'($urandom_range(0, 31));
                  it.table_value    = GAIN_W'($urandom_range(0, 511));
                  if ($urandom_range(0, 15) == 0)
                     it.sample = $urandom_range(0, 1) ? LEVEL_FULL : LEVEL_ZERO;
                  idle_sender();
                  send_item(it, 1'b0, '0);
                  sent++;
               end
               n = $urandom_range(1, 3);
               for (int k = 0; k < n; k++) begin
                  it.kind           = OP_TICK;
                  it.sample         = LEVEL_W'($urandom_range(0, 255));
                  it.start_of_block = 1'($urandom_range(0, 1));
                  idle_sender();
                  send_item(it, 1'b0, '0);
                  sent++;
               end
            end else if (pick < 85) begin
               it.kind           = OP_LOAD;
               it.sample         = LEVEL_W'($urandom_range(0, 255));
               it.start_of_block = 1'($urandom_range(0, 1));
               it.table_index    = IDX_W'($urandom_range(0, 31));
               // mostly keep the table ascending, sometimes break it
               it.table_value    = ($urandom_range(0, 3) == 0) ?
                                   GAIN_W'($urandom_range(0, 511)) :
                                   GAIN_W'(it.table_index * GAIN_STEP + $urandom_range(0, 14));
               idle_sender();
               send_item(it, 1'b0, '0);
               sent++;
            end else begin
               it.kind           = op_type'($urandom_range(0, 3));
               it.sample         = LEVEL_W'($urandom_range(0, 255));
               it.start_of_block = 1'($urandom_range(0, 1));
               it.table_index    = IDX_W'($urandom_range(0, 31));
               it.table_value    = GAIN_W'($urandom_range(0, 511));
               idle_sender();
               send_item(it, 1'b0, '0);
               sent++;
            end
         end
      end
      req_bus.valid <= 1'b0;

      while (expected_reports.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pbgs_pkg.sv
rtl/pbgs_if.sv
rtl/pbgs_front.sv
rtl/pbgs_factor.sv
rtl/pbgs_back.sv
rtl/peak_based_gain_stepper.sv
dv/tb_top.sv
